// ===== rtl/ilpm_pkg.sv =====
// Shared constants and control types for the interrupt load permille monitor.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package ilpm_pkg;

   // Payload widths of the channels.
   localparam int TIMESTAMP_BITS = 32;
   localparam int LOAD_BITS      = 11;

   // Default width of the cycle counter arithmetic.
   localparam int COUNTER_BITS_DEF = 32;

   // Quotient bits of the permille division; the result stays below 2048.
   localparam int QUOT_BITS = 11;

   // Scale factor 1000 is formed as 1024 - 16 - 8.
   localparam int SCALE_SHIFT   = 10;
   localparam int SCALE_SUB_HI  = 4;
   localparam int SCALE_SUB_LO  = 3;

   // Saturated load value.
   localparam logic [LOAD_BITS-1:0] LOAD_LIMIT = LOAD_BITS'(2000);

   // Event kinds.
   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_EXIT  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // A request is accepted this cycle.
      logic scale;        // Form the first part of busy * 1000 and the saturation test.
      logic prep;         // Finish the product and load the divider.
      logic div_step;     // One restoring division step.
      logic commit;       // Store the new load and update the peak.
      logic rsp_load;     // Load the response register.
      logic rsp_updated;  // Value of the updated flag for the response.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exit_work;    // The presented request is an exit that computes a load.
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/ilpm_channels_if.sv =====
// Valid/ready channel interfaces for requests, responses and the register write port.
// Payload widths come from ilpm_pkg.
`default_nettype none

// Event request channel.
interface ilpm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic [ilpm_pkg::TIMESTAMP_BITS-1:0]  timestamp;

   modport source (output valid, output kind, output timestamp, input ready);
   modport sink   (input valid, input kind, input timestamp, output ready);
endinterface

// Load report channel.
interface ilpm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ilpm_pkg::LOAD_BITS-1:0]  load_permille;
   logic [ilpm_pkg::LOAD_BITS-1:0]  max_permille;
   logic                            load_updated;

   modport source (output valid, output load_permille, output max_permille,
                   output load_updated, input ready);
   modport sink   (input valid, input load_permille, input max_permille,
                   input load_updated, output ready);
endinterface

// Register write channel for counter_valid.
interface ilpm_csr_if;
   logic valid;
   logic ready;
   logic counter_valid;

   modport source (output valid, output counter_valid, input ready);
   modport sink   (input valid, input counter_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilpm_ctrl.sv =====
// Sequencing controller of the load monitor: request/response handshakes and
// the steps of the load computation. Depends on ilpm_pkg.
`default_nettype none

module ilpm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ilpm_pkg::status_type status,
   output      ilpm_pkg::cmd_type    cmd
);

   localparam int CntBits = (ilpm_pkg::QUOT_BITS > 1) ? $clog2(ilpm_pkg::QUOT_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_PREP,
      ST_DIVIDE,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   state_type          state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;
   logic               accept;

   // The response register can take a new value when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               if (status.exit_work) begin
                  state_in = ST_SCALE;
               end else begin
                  cmd.rsp_load = 1'b1;
               end
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = CntBits'(ilpm_pkg::QUOT_BITS - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CntBits'(1);
            if (cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_updated = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid follows the response register loads and drains.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ilpm_datapath.sv =====
// Datapath of the load monitor: timestamps, period, shift-and-add scaling,
// restoring divider, load and peak registers, response payload. Depends on ilpm_pkg.
`default_nettype none

module ilpm_datapath #(
   parameter int COUNTER_BITS = ilpm_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_kind,
   input  wire logic [ilpm_pkg::TIMESTAMP_BITS-1:0]  req_timestamp,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic                                 csr_counter_valid,
   input  wire ilpm_pkg::cmd_type                    cmd,
   output      ilpm_pkg::status_type                 status,
   output      logic [ilpm_pkg::LOAD_BITS-1:0]       rsp_load_permille,
   output      logic [ilpm_pkg::LOAD_BITS-1:0]       rsp_max_permille,
   output      logic                                 rsp_load_updated
);

   localparam int WideBits = COUNTER_BITS + ilpm_pkg::SCALE_SHIFT;
   localparam int QB       = ilpm_pkg::QUOT_BITS;
   localparam int LB       = ilpm_pkg::LOAD_BITS;

   logic                    counter_valid_ff, counter_valid_in;
   logic [COUNTER_BITS-1:0] entry_ff, entry_in;
   logic [COUNTER_BITS-1:0] period_ff, period_in;
   logic [COUNTER_BITS-1:0] busy_ff, busy_in;
   logic                    sat_ff, sat_in;
   logic [WideBits-1:0]     prod_ff, prod_in;
   logic [WideBits-1:0]     rem_ff, rem_in;
   logic [WideBits-1:0]     div_ff, div_in;
   logic [QB-1:0]           quot_ff, quot_in;
   logic [LB-1:0]           current_ff, current_in;
   logic [LB-1:0]           peak_ff, peak_in;
   logic [LB-1:0]           rsp_load_ff, rsp_load_in;
   logic [LB-1:0]           rsp_max_ff, rsp_max_in;
   logic                    rsp_upd_ff, rsp_upd_in;

   logic [COUNTER_BITS-1:0] now;
   logic [COUNTER_BITS-1:0] elapsed;
   logic [WideBits-1:0]     busy_wide;
   logic                    ge;
   logic [LB-1:0]           load_new;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   // Timestamp reduced to the counter width and the wrapped distance from the last entry.
   assign now       = COUNTER_BITS'(req_timestamp);
   assign elapsed   = now - entry_ff;
   assign busy_wide = WideBits'(busy_ff);

   assign status.exit_work = counter_valid_ff && (req_kind == ilpm_pkg::KIND_EXIT)
                             && (period_ff != '0);

   // Event capture: entries update period and entry time, exits latch the busy time.
   always_comb begin
      counter_valid_in = counter_valid_ff;
      entry_in         = entry_ff;
      period_in        = period_ff;
      busy_in          = busy_ff;
      if (csr_valid && csr_ready) begin
         counter_valid_in = csr_counter_valid;
      end
      if (cmd.capture && counter_valid_ff) begin
         if (req_kind == ilpm_pkg::KIND_ENTRY) begin
            period_in = elapsed;
            entry_in  = now;
         end else begin
            busy_in = elapsed;
         end
      end
   end

   // Scaling by 1000 in two subtractions, then the restoring division steps.
   assign ge = (rem_ff >= div_ff);

   always_comb begin
      sat_in  = sat_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      if (cmd.scale) begin
         sat_in  = ({1'b0, busy_ff} >= {period_ff, 1'b0});
         prod_in = (busy_wide << ilpm_pkg::SCALE_SHIFT)
                   - (busy_wide << ilpm_pkg::SCALE_SUB_HI);
      end
      if (cmd.prep) begin
         rem_in  = prod_ff - (busy_wide << ilpm_pkg::SCALE_SUB_LO);
         div_in  = WideBits'(period_ff) << (QB - 1);
         quot_in = '0;
      end
      if (cmd.div_step) begin
         if (ge) begin
            rem_in = rem_ff - div_ff;
         end
         div_in  = div_ff >> 1;
         quot_in = {quot_ff[QB-2:0], ge};
      end
   end

   // Load commit with saturation and peak tracking.
   assign load_new = sat_ff ? ilpm_pkg::LOAD_LIMIT : LB'(quot_ff);

   always_comb begin
      current_in = current_ff;
      peak_in    = peak_ff;
      if (cmd.commit) begin
         current_in = load_new;
         if (load_new > peak_ff) begin
            peak_in = load_new;
         end
      end
   end

   // Response payload register.
   always_comb begin
      rsp_load_in = rsp_load_ff;
      rsp_max_in  = rsp_max_ff;
      rsp_upd_in  = rsp_upd_ff;
      if (cmd.rsp_load) begin
         rsp_load_in = current_ff;
         rsp_max_in  = peak_ff;
         rsp_upd_in  = cmd.rsp_updated;
      end
   end

   assign rsp_load_permille = rsp_load_ff;
   assign rsp_max_permille  = rsp_max_ff;
   assign rsp_load_updated  = rsp_upd_ff;

   // Architectural state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_valid_ff <= 1'b0;
         entry_ff         <= '0;
         period_ff        <= '0;
         current_ff       <= '0;
         peak_ff          <= '0;
      end else begin
         counter_valid_ff <= counter_valid_in;
         entry_ff         <= entry_in;
         period_ff        <= period_in;
         current_ff       <= current_in;
         peak_ff          <= peak_in;
      end
   end

   // Working registers and response payload.
   always_ff @(posedge clock) begin
      busy_ff     <= busy_in;
      sat_ff      <= sat_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      rsp_load_ff <= rsp_load_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

endmodule

`default_nettype wire

// ===== rtl/interrupt_load_permille_monitor_unit.sv =====
// Top level of the interrupt load permille monitor.
// Instantiates ilpm_ctrl and ilpm_datapath; uses ilpm_pkg and the channel interfaces.
//
// Usage:
//   req_channel carries interrupt events (kind 0 entry, 1 exit) with a cycle
//   counter timestamp. rsp_channel returns one report per request: current
//   load, peak load (both permille, 0..2000) and whether a new load was computed.
//   csr_channel writes counter_valid; while it is 0 every event leaves the
//   state alone. The register port is always ready.
// Sequencing:
//   An entry, an ignored exit or any event while counter_valid is 0 is
//   reported in the cycle after acceptance, and the next request can follow
//   in the next cycle if the receiver takes the report. An exit that computes
//   a load passes from acceptance to its report through a scaling step, a
//   preparation step, 11 steps of the one-bit-per-cycle restoring divider,
//   a commit step and the response register load; no request is taken meanwhile.
// Reset:
//   Synchronous, active high. Clears counter_valid, entry time, period,
//   current and peak load, and empties the response register.
// Stalls:
//   A finished report waits in the response register while the receiver
//   holds ready low; a new request is taken only when that register is
//   free or is being drained in the same cycle.
`default_nettype none

module interrupt_load_permille_monitor_unit #(
   parameter int COUNTER_BITS = ilpm_pkg::COUNTER_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   ilpm_req_if.sink   req_channel,
   ilpm_rsp_if.source rsp_channel,
   ilpm_csr_if.sink   csr_channel
);

   ilpm_pkg::cmd_type    cmd;
   ilpm_pkg::status_type status;
   logic                 ctrl_req_ready;
   logic                 ctrl_rsp_valid;
   logic                 dp_csr_ready;
   logic [ilpm_pkg::LOAD_BITS-1:0] dp_load;
   logic [ilpm_pkg::LOAD_BITS-1:0] dp_max;
   logic                 dp_updated;

   // Sequencer for handshakes and the load computation.
   ilpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, state and response payload.
   ilpm_datapath #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req_channel.kind),
      .req_timestamp     (req_channel.timestamp),
      .csr_valid         (csr_channel.valid),
      .csr_ready         (dp_csr_ready),
      .csr_counter_valid (csr_channel.counter_valid),
      .cmd               (cmd),
      .status            (status),
      .rsp_load_permille (dp_load),
      .rsp_max_permille  (dp_max),
      .rsp_load_updated  (dp_updated)
   );

   // Channel signal hookup.
   assign req_channel.ready         = ctrl_req_ready;
   assign csr_channel.ready         = dp_csr_ready;
   assign rsp_channel.valid         = ctrl_rsp_valid;
   assign rsp_channel.load_permille = dp_load;
   assign rsp_channel.max_permille  = dp_max;
   assign rsp_channel.load_updated  = dp_updated;

endmodule

`default_nettype wire

// ===== verif/ilpm_load_check.sv =====
`timescale 1ns / 100ps
// Checker for interrupt_load_permille_monitor_unit: watches the event, report and
// register channels, predicts every load report and compares it field by field.
// Depends on ilpm_pkg and the channel interfaces in ilpm_channels_if.sv.
module ilpm_load_check (
   input  logic clock,
   input  logic reset,
   ilpm_req_if  req_mon,
   ilpm_rsp_if  rsp_mon,
   ilpm_csr_if  csr_mon,
   output int   failures,
   output int   outstanding,
   output int   load_updates
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [ilpm_pkg::LOAD_BITS-1:0] load_permille;
      logic [ilpm_pkg::LOAD_BITS-1:0] max_permille;
      logic                           load_updated;
   } load_report_type;

   // Reports predicted for accepted requests, oldest first.
   load_report_type expected_reports[$];

   // Shadow of the unit's register and state.
   logic                                counter_ok;
   logic [ilpm_pkg::TIMESTAMP_BITS-1:0] entry_stamp;
   logic [ilpm_pkg::TIMESTAMP_BITS-1:0] period_cycles;
   logic [ilpm_pkg::LOAD_BITS-1:0]      load_now;
   logic [ilpm_pkg::LOAD_BITS-1:0]      load_peak;
   int                                  mismatch_count;
   int                                  update_count;

   // Busy fraction of the period in permille, saturated at the load limit.
   function automatic logic [ilpm_pkg::LOAD_BITS-1:0] permille_of(
      input logic [ilpm_pkg::TIMESTAMP_BITS-1:0] busy,
      input logic [ilpm_pkg::TIMESTAMP_BITS-1:0] period
   );
      logic [63:0] quotient;
      if ({1'b0, busy} >= {period, 1'b0}) return ilpm_pkg::LOAD_LIMIT;
      quotient = (64'(busy) * 64'd1000) / 64'(period);
      if (quotient > 64'(ilpm_pkg::LOAD_LIMIT)) return ilpm_pkg::LOAD_LIMIT;
      return quotient[ilpm_pkg::LOAD_BITS-1:0];
   endfunction

   // Applies one event to the shadow state and queues the report it causes.
   task automatic account_event(input logic kind,
                                input logic [ilpm_pkg::TIMESTAMP_BITS-1:0] stamp);
      load_report_type report;
      report.load_updated = 1'b0;
      if (counter_ok) begin
         if (kind == ilpm_pkg::KIND_ENTRY) begin
            period_cycles = stamp - entry_stamp;
            entry_stamp   = stamp;
         end else if (period_cycles != '0) begin
            load_now = permille_of(stamp - entry_stamp, period_cycles);
            if (load_now > load_peak) load_peak = load_now;
            report.load_updated = 1'b1;
            update_count++;
         end
      end
      report.load_permille = load_now;
      report.max_permille  = load_peak;
      expected_reports.push_back(report);
   endtask

   always @(posedge clock) begin
      load_report_type got;
      load_report_type want;
      if (reset) begin
         expected_reports.delete();
         counter_ok     = 1'b0;
         entry_stamp    = '0;
         period_cycles  = '0;
         load_now       = '0;
         load_peak      = '0;
         mismatch_count = 0;
         update_count   = 0;
      end else begin
         // Reports are matched before new requests so that a report never meets
         // the expectation of a request accepted at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.load_permille = rsp_mon.load_permille;
            got.max_permille  = rsp_mon.max_permille;
            got.load_updated  = rsp_mon.load_updated;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: report load %0d max %0d updated %0b with none expected",
                           $realtime, got.load_permille, got.max_permille, got.load_updated);
            end else begin
               want = expected_reports.pop_front();
               if (got.load_permille != want.load_permille ||
                   got.max_permille != want.max_permille ||
                   got.load_updated != want.load_updated) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("%0t: report mismatch: expected load %0d max %0d updated %0b,",
                            $realtime, want.load_permille, want.max_permille,
                            want.load_updated);
                     $display(" got load %0d max %0d updated %0b",
                              got.load_permille, got.max_permille, got.load_updated);
                  end
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) counter_ok = csr_mon.counter_valid;
         if (req_mon.valid && req_mon.ready) account_event(req_mon.kind, req_mon.timestamp);
      end
      failures     <= mismatch_count;
      outstanding  <= expected_reports.size();
      load_updates <= update_count;
   end

endmodule

// ===== verif/interrupt_load_permille_monitor_unit_test.sv =====
`timescale 1ns / 100ps
// Stimulus top for interrupt_load_permille_monitor_unit: drives events, register
// writes and report backpressure, and gives the verdict from ilpm_load_check.
// Depends on ilpm_pkg, the channel interfaces, the unit and ilpm_load_check.
module interrupt_load_permille_monitor_unit_test;

   localparam int GAP_LIMIT        = 19;
   localparam int END_DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   load_updates;
   int   send_gap_max   = GAP_LIMIT;
   int   accept_gap_max = GAP_LIMIT;
   int   events_sent    = 0;
   logic [ilpm_pkg::TIMESTAMP_BITS-1:0] last_entry_stamp = '0;

   ilpm_req_if req_bus();
   ilpm_rsp_if rsp_bus();
   ilpm_csr_if csr_bus();

   interrupt_load_permille_monitor_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus),
      .csr_channel (csr_bus)
   );

   ilpm_load_check load_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_mon      (csr_bus),
      .failures     (failures),
      .outstanding  (outstanding),
      .load_updates (load_updates)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the unit hangs.
   initial begin
      #5_000_000;
      $display("interrupt_load_permille_monitor_unit verification failed");
      $finish;
   end

   // Report receiver: holds ready low for a random number of cycles per report.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, accept_gap_max);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Span of cycles spread over all magnitudes, sometimes zero.
   function automatic logic [ilpm_pkg::TIMESTAMP_BITS-1:0] pick_span();
      if ($urandom_range(0, 15) == 0) return '0;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // Presents one event after a random gap and waits for its request to be taken.
   task automatic send_event(input logic kind,
                             input logic [ilpm_pkg::TIMESTAMP_BITS-1:0] stamp);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.timestamp <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      events_sent++;
   endtask

   // Stops sending and waits until every predicted report has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_counter_valid(input logic value);
      csr_bus.valid         <= 1'b1;
      csr_bus.counter_valid <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly entry/exit pairs with random period and busy time; the rest is noise.
   task automatic run_random_events(input int count);
      int                                  sent;
      int                                  exits;
      logic                                kind;
      logic [ilpm_pkg::TIMESTAMP_BITS-1:0] span;
      logic [ilpm_pkg::TIMESTAMP_BITS-1:0] busy;
      logic [ilpm_pkg::TIMESTAMP_BITS-1:0] stamp;
      logic [63:0]                         wide;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            span = pick_span();
            last_entry_stamp = last_entry_stamp + span;
            send_event(ilpm_pkg::KIND_ENTRY, last_entry_stamp);
            exits = $urandom_range(1, 2);
            repeat (exits) begin
               // Busy time in eighths of the period, up to past saturation.
               if ($urandom_range(0, 1) == 1) begin
                  wide = (64'(span) * 64'($urandom_range(0, 20))) >> 3;
                  busy = wide[ilpm_pkg::TIMESTAMP_BITS-1:0];
               end else begin
                  busy = pick_span();
               end
               send_event(ilpm_pkg::KIND_EXIT, last_entry_stamp + busy);
            end
            sent += 1 + exits;
         end else begin
            kind  = 1'($urandom_range(0, 1));
            stamp = $urandom;
            if (kind == ilpm_pkg::KIND_ENTRY) last_entry_stamp = stamp;
            send_event(kind, stamp);
            sent++;
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= ilpm_pkg::KIND_ENTRY;
      req_bus.timestamp     <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.counter_valid <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Events while the counter is not valid change nothing.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h0000_1000);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_2000);
      wait_drained();
      write_counter_valid(1'b1);

      // Exit before any entry has been seen: zero period, ignored.
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_0005);
      // Largest period, zero busy time, then busy time wrapping to all ones.
      send_event(ilpm_pkg::KIND_ENTRY, 32'hFFFF_FFFF);
      send_event(ilpm_pkg::KIND_EXIT,  32'hFFFF_FFFF);
      send_event(ilpm_pkg::KIND_EXIT,  32'hFFFF_FFFE);
      // Period of ten across the counter wrap; just below and at twice the period.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h0000_0009);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_001C);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_001D);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_000F);
      // Two entries at the same time give a zero period; the exit is ignored.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h0000_0009);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_0010);
      // Period of one cycle.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h0000_000A);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_000B);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_000A);
      // Fraction with a remainder.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h0000_000D);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_0012);
      // Half-range period with busy times around it and just below saturation.
      send_event(ilpm_pkg::KIND_ENTRY, 32'h8000_000D);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_000C);
      send_event(ilpm_pkg::KIND_EXIT,  32'h0000_000D);
      send_event(ilpm_pkg::KIND_EXIT,  32'h8000_000C);
      // Alternating bit patterns, saturating.
      send_event(ilpm_pkg::KIND_ENTRY, 32'hAAAA_AAAA);
      send_event(ilpm_pkg::KIND_EXIT,  32'h5555_5555);
      last_entry_stamp = 32'hAAAA_AAAA;
      wait_drained();

      // Random traffic with gaps on both sides.
      run_random_events(250);
      wait_drained();

      // Counter marked invalid: every event is ignored.
      write_counter_valid(1'b0);
      run_random_events(40);
      wait_drained();
      write_counter_valid(1'b1);

      // Back-to-back traffic with no gaps at all.
      send_gap_max   = 0;
      accept_gap_max = 0;
      run_random_events(120);
      wait_drained();

      // Fast sender against a slow receiver.
      accept_gap_max = GAP_LIMIT;
      run_random_events(110);

      // Gaps on both sides again.
      send_gap_max = GAP_LIMIT;
      run_random_events(120);

      wait_drained();
      repeat (END_DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d interrupt events, %0d of which produced a new load value,",
               events_sent, load_updates);
      $display("with the counter both valid and invalid and with and without stalls.");
      if (failures == 0)
         $display("interrupt_load_permille_monitor_unit verification clean");
      else
         $display("interrupt_load_permille_monitor_unit verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ilpm_pkg.sv
rtl/ilpm_channels_if.sv
rtl/ilpm_ctrl.sv
rtl/ilpm_datapath.sv
rtl/interrupt_load_permille_monitor_unit.sv
verif/ilpm_load_check.sv
verif/interrupt_load_permille_monitor_unit_test.sv
